FILE: rtl/wmd_pkg.sv
// Shared definitions for the waveform min/max decimator.
// Constants, register indexes, bin snapshot types and helper functions.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package wmd_pkg;

  // Block dimensions
  localparam int BINS         = 512;
  localparam int MAX_CHANNELS = 8;

  // Field and datapath widths
  localparam int CODE_W     = 8;
  localparam int SPAN_W     = 32;
  localparam int CCOUNT_W   = 4;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;
  localparam int BIN_NUM_W  = 9;
  localparam int CH_NUM_W   = 3;
  localparam int ACC_W      = 48;
  localparam int BIN_W      = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int CH_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W      = $clog2(MAX_CHANNELS + 1);

  // Bin snapshot queue
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Offset-binary conversion and empty-bin codes
  localparam logic [CODE_W-1:0] CODE_OFFSET = 8'h80;
  localparam logic [CODE_W-1:0] MAX_EMPTY   = 8'd0;
  localparam logic [CODE_W-1:0] MIN_EMPTY   = 8'd255;

  // Reset values of the configuration registers
  localparam logic [SPAN_W-1:0]   SPAN_RESET   = 32'd512;
  localparam logic [CCOUNT_W-1:0] CCOUNT_RESET = 4'd1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIN_SPAN      = 4'd0,
    REG_CHANNEL_COUNT = 4'd1
  } cfg_reg_t;

  typedef logic [CODE_W-1:0] code_t;

  // One finished bin: all channel extremes plus its bin number
  typedef struct packed {
    logic [BIN_W-1:0]              bin;
    code_t [MAX_CHANNELS-1:0]      max_codes;
    code_t [MAX_CHANNELS-1:0]      min_codes;
    logic                          last;
  } snap_t;

  // Up to two finished bins per item: a crossing and an end of data
  typedef struct packed {
    logic  a_valid;
    snap_t a;
    logic  b_valid;
    snap_t b;
  } q_push_t;

  // Clamp the channel count register to 1 .. MAX_CHANNELS
  function automatic logic [CNT_W-1:0] eff_channels(input logic [CCOUNT_W-1:0] cc);
    logic [CNT_W-1:0] c;
    if (cc == '0) begin
      c = CNT_W'(1);
    end else if ({1'b0, cc} > (CCOUNT_W + 1)'(MAX_CHANNELS)) begin
      c = CNT_W'(MAX_CHANNELS);
    end else begin
      c = CNT_W'(cc);
    end
    return c;
  endfunction

endpackage

FILE: rtl/wmd_ifs.sv
// Valid/ready channel interfaces of the waveform min/max decimator.
// Sample input, result output and configuration write channels.
// Depends on wmd_pkg.
`timescale 1ns / 1ps

interface wmd_in_if;
  import wmd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [CODE_W-1:0] high_value;
  logic signed [CODE_W-1:0] low_value;
  logic                    end_of_data;

  modport source (output valid, output high_value, output low_value,
                  output end_of_data, input ready);
  modport sink   (input valid, input high_value, input low_value,
                  input end_of_data, output ready);
endinterface

interface wmd_out_if;
  import wmd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [BIN_NUM_W-1:0] bin_number;
  logic [CH_NUM_W-1:0]  channel_number;
  logic [CODE_W-1:0]    max_code;
  logic [CODE_W-1:0]    min_code;
  logic                 last_of_run;

  modport source (output valid, output bin_number, output channel_number,
                  output max_code, output min_code, output last_of_run, input ready);
  modport sink   (input valid, input bin_number, input channel_number,
                  input max_code, input min_code, input last_of_run, output ready);
endinterface

interface wmd_cfg_if;
  import wmd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/wmd_bin_queue.sv
// Finished-bin queue and result serializer of the min/max decimator.
// Holds up to Q_DEPTH bin snapshots and sends one result per channel of each snapshot.
// Depends on wmd_pkg and wmd_out_if.
`timescale 1ns / 1ps

module wmd_bin_queue import wmd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  q_push_t          push,
  input  logic [CNT_W-1:0] chan_eff,
  output logic [Q_CNT_W-1:0] count,
  wmd_out_if.source        result_out
);

  snap_t                q_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [CH_W-1:0]      ch_idx;
  logic                 out_valid;
  logic [BIN_NUM_W-1:0] out_bin;
  logic [CH_NUM_W-1:0]  out_channel;
  code_t                out_max;
  code_t                out_min;
  logic                 out_last;

  snap_t                head;
  logic                 load;
  logic                 last_ch;
  logic [Q_CNT_W-1:0]   push_n;
  logic [Q_CNT_W-1:0]   pop_n;

  // Pick the next channel result from the oldest snapshot
  assign head    = q_mem[rd_ptr];
  assign load    = (count != '0) && (!out_valid || result_out.ready);
  assign last_ch = (CNT_W'(ch_idx) + CNT_W'(1)) == chan_eff;
  assign push_n  = Q_CNT_W'(push.a_valid) + Q_CNT_W'(push.b_valid);
  assign pop_n   = Q_CNT_W'(load && last_ch);

  // Store snapshots; a crossing bin goes in ahead of an end-of-data bin
  always_ff @(posedge clk) begin
    if (push.a_valid) begin
      q_mem[wr_ptr] <= push.a;
    end
    if (push.b_valid) begin
      q_mem[push.a_valid ? wr_ptr + Q_PTR_W'(1) : wr_ptr] <= push.b;
    end
  end

  // Advance pointers, occupancy and channel counter
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      ch_idx <= '0;
    end else begin
      wr_ptr <= wr_ptr + Q_PTR_W'(push_n);
      count  <= count + push_n - pop_n;
      if (load) begin
        if (last_ch) begin
          rd_ptr <= rd_ptr + Q_PTR_W'(1);
          ch_idx <= '0;
        end else begin
          ch_idx <= ch_idx + CH_W'(1);
        end
      end
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_bin     <= BIN_NUM_W'(head.bin);
      out_channel <= CH_NUM_W'(ch_idx);
      out_max     <= head.max_codes[ch_idx];
      out_min     <= head.min_codes[ch_idx];
      out_last    <= head.last && last_ch;
    end
  end

  assign result_out.valid          = out_valid;
  assign result_out.bin_number     = out_bin;
  assign result_out.channel_number = out_channel;
  assign result_out.max_code       = out_max;
  assign result_out.min_code       = out_min;
  assign result_out.last_of_run    = out_last;

endmodule

FILE: rtl/waveform_minmax_decimator_top.sv
// Top level of the waveform min/max decimator.
// Bin tracking, per-channel extremes and configuration; uses wmd_pkg,
// the channel interfaces and wmd_bin_queue.
`timescale 1ns / 1ps

// Takes one channel byte pair per cycle and reduces the stream to BINS
// min/max display bins. An accepted request passes an input register and the
// bin logic (a 48-bit compare and add); a finished bin is copied
// whole into a four-entry queue and sent as one result per channel, one per
// cycle while the output is ready, so the first result of a bin is registered
// in the queue and then in the output register. Input is taken every cycle
// while the queue has room for two bins; a run of closing bins is limited by
// the output at one result per cycle, one result for each channel of a bin.
// After reset and after every register write the block restarts the run (bin
// step multiply, state clear) with input ready low; registers may be written only
// while the block is idle.

module waveform_minmax_decimator_top import wmd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  wmd_in_if.sink     sample_in,
  wmd_out_if.source  result_out,
  wmd_cfg_if.sink    cfg
);

  // Configuration and derived steps
  logic [SPAN_W-1:0]   bin_span;
  logic [CCOUNT_W-1:0] channel_count;
  logic [CNT_W-1:0]    chan_eff;
  logic [ACC_W-1:0]    bin_step;
  logic [ACC_W-1:0]    sample_step;
  logic                restart_pending;
  logic [CNT_W-1:0]    ce_calc;
  logic [ACC_W-1:0]    step_calc;

  // Input register
  logic                stg_valid;
  logic signed [CODE_W-1:0] stg_high;
  logic signed [CODE_W-1:0] stg_low;
  logic                stg_eod;
  logic                stg_go;

  // Run state
  code_t [MAX_CHANNELS-1:0] running_max;
  code_t [MAX_CHANNELS-1:0] running_min;
  logic [CH_W-1:0]     chan_pos;
  logic [BIN_W-1:0]    current_bin;
  logic [ACC_W-1:0]    thr_acc;
  logic [ACC_W-1:0]    bnd_acc;
  logic                run_finished;

  // Next-state values
  code_t [MAX_CHANNELS-1:0] running_max_next;
  code_t [MAX_CHANNELS-1:0] running_min_next;
  logic [CH_W-1:0]     chan_pos_next;
  logic [BIN_W-1:0]    current_bin_next;
  logic [ACC_W-1:0]    thr_acc_next;
  logic [ACC_W-1:0]    bnd_acc_next;
  logic                run_finished_next;
  logic [CH_W-1:0]     pos;
  logic                closing_last;
  code_t               hi_code;
  code_t               lo_code;
  q_push_t             push;
  logic [Q_CNT_W-1:0]  q_count;

  // Configuration writes never stall
  assign cfg.ready = 1'b1;

  // Restart values from the current registers
  assign ce_calc   = eff_channels(channel_count);
  assign step_calc = ACC_W'(bin_span) * ACC_W'({ce_calc, 1'b0});

  // Store register writes and schedule a restart
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_span        <= SPAN_RESET;
      channel_count   <= CCOUNT_RESET;
      restart_pending <= 1'b1;
    end else if (cfg.valid && cfg.index == REG_BIN_SPAN) begin
      bin_span        <= cfg.data;
      restart_pending <= 1'b1;
    end else if (cfg.valid && cfg.index == REG_CHANNEL_COUNT) begin
      channel_count   <= cfg.data[CCOUNT_W-1:0];
      restart_pending <= 1'b1;
    end else begin
      restart_pending <= 1'b0;
    end
  end

  // Input register handshake; hold off while restarting or the queue lacks room for two bins
  assign stg_go = stg_valid && !restart_pending &&
                  (run_finished || q_count <= Q_CNT_W'(Q_DEPTH - 2));
  assign sample_in.ready = !restart_pending && (!stg_valid || stg_go);

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (sample_in.ready) begin
      stg_valid <= sample_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_in.valid && sample_in.ready) begin
      stg_high <= sample_in.high_value;
      stg_low  <= sample_in.low_value;
      stg_eod  <= sample_in.end_of_data;
    end
  end

  // Bin logic for the staged request
  assign hi_code = code_t'(stg_high) ^ CODE_OFFSET;
  assign lo_code = code_t'(stg_low) ^ CODE_OFFSET;
  assign pos     = (CNT_W'(chan_pos) >= chan_eff) ? '0 : chan_pos;

  always_comb begin
    running_max_next  = running_max;
    running_min_next  = running_min;
    chan_pos_next     = chan_pos;
    current_bin_next  = current_bin;
    thr_acc_next      = thr_acc;
    bnd_acc_next      = bnd_acc;
    run_finished_next = run_finished;
    closing_last      = 1'b0;
    push              = '0;
    if (stg_go && !run_finished) begin
      // Close the current bin when this sample passes its boundary
      if (pos == '0 && thr_acc > bnd_acc) begin
        push.a_valid       = 1'b1;
        push.a.bin         = current_bin;
        push.a.max_codes   = running_max;
        push.a.min_codes   = running_min;
        if (current_bin == BIN_W'(BINS - 1)) begin
          push.a.last       = 1'b1;
          run_finished_next = 1'b1;
          closing_last      = 1'b1;
        end else begin
          push.a.last      = 1'b0;
          current_bin_next = current_bin + BIN_W'(1);
          bnd_acc_next     = bnd_acc + bin_step;
          for (int i = 0; i < MAX_CHANNELS; i++) begin
            running_max_next[i] = MAX_EMPTY;
            running_min_next[i] = MIN_EMPTY;
          end
        end
      end
      if (!closing_last) begin
        if (pos == '0) begin
          thr_acc_next = thr_acc + sample_step;
        end
        // Fold this channel's bytes into the bin
        if (hi_code > running_max_next[pos]) begin
          running_max_next[pos] = hi_code;
        end
        if (lo_code < running_min_next[pos]) begin
          running_min_next[pos] = lo_code;
        end
        // End of data closes the bin as it now stands
        if (stg_eod) begin
          push.b_valid      = 1'b1;
          push.b.bin        = current_bin_next;
          push.b.max_codes  = running_max_next;
          push.b.min_codes  = running_min_next;
          push.b.last       = 1'b1;
          run_finished_next = 1'b1;
        end else if ((CNT_W'(pos) + CNT_W'(1)) >= chan_eff) begin
          chan_pos_next = '0;
        end else begin
          chan_pos_next = pos + CH_W'(1);
        end
      end
    end
  end

  // Run state: restart or advance
  always_ff @(posedge clk) begin
    if (rst) begin
      run_finished <= 1'b0;
      chan_pos     <= '0;
      current_bin  <= '0;
    end else if (restart_pending) begin
      run_finished <= 1'b0;
      chan_pos     <= '0;
      current_bin  <= '0;
    end else begin
      run_finished <= run_finished_next;
      chan_pos     <= chan_pos_next;
      current_bin  <= current_bin_next;
    end
  end

  always_ff @(posedge clk) begin
    if (restart_pending) begin
      chan_eff    <= ce_calc;
      bin_step    <= step_calc;
      sample_step <= ACC_W'(ce_calc) * ACC_W'(2 * BINS);
      thr_acc     <= ACC_W'(BINS);
      bnd_acc     <= step_calc;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        running_max[i] <= MAX_EMPTY;
        running_min[i] <= MIN_EMPTY;
      end
    end else begin
      thr_acc     <= thr_acc_next;
      bnd_acc     <= bnd_acc_next;
      running_max <= running_max_next;
      running_min <= running_min_next;
    end
  end

  // Finished bins out, one channel per result
  wmd_bin_queue u_bin_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .chan_eff   (chan_eff),
    .count      (q_count),
    .result_out (result_out)
  );

endmodule

FILE: rtl/wmd_checker.sv
// Port-level checks for the waveform min/max decimator.
// Watches the top level's channels only; bound to the top level below.
// Depends on wmd_pkg.
`timescale 1ns / 1ps

module wmd_checker import wmd_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_ready,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [BIN_NUM_W-1:0] out_bin,
  input logic [CH_NUM_W-1:0]  out_channel,
  input logic [CODE_W-1:0]    out_max,
  input logic [CODE_W-1:0]    out_min,
  input logic                 out_last
);

  // No result straight out of reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable({out_bin, out_channel, out_max, out_min, out_last}))
    else $error("stalled result changed or dropped");

  // Nothing follows the last result of a run
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_last |=> !out_valid)
    else $error("result after end of run");

  // Restart after reset or a register write holds off input
  a_restart_gap: assert property (@(posedge clk)
    rst || (cfg_valid && cfg_ready) |=> !in_ready)
    else $error("input ready during restart");

endmodule

bind waveform_minmax_decimator_top wmd_checker u_wmd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (sample_in.ready),
  .cfg_valid   (cfg.valid),
  .cfg_ready   (cfg.ready),
  .out_valid   (result_out.valid),
  .out_ready   (result_out.ready),
  .out_bin     (result_out.bin_number),
  .out_channel (result_out.channel_number),
  .out_max     (result_out.max_code),
  .out_min     (result_out.min_code),
  .out_last    (result_out.last_of_run)
);

FILE: test/waveform_minmax_decimator_top_test.sv
// Testbench for the waveform min/max decimator top level.
// Predicts every bin result from the accepted requests and checks results in order;
// depends on wmd_pkg, the channel interfaces and waveform_minmax_decimator_top.
`timescale 1ns / 1ps

module waveform_minmax_decimator_top_test;
  import wmd_pkg::*;

  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 250;
  localparam int QUIET_ITEMS   = 40;
  localparam int DRAIN_LIMIT   = 50000;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [BIN_NUM_W-1:0] bin;
    logic [CH_NUM_W-1:0]  channel;
    code_t                max_c;
    code_t                min_c;
    logic                 last;
  } bin_result_t;

  logic clk;
  logic rst;

  wmd_in_if  sample_in();
  wmd_out_if result_out();
  wmd_cfg_if cfg();

  waveform_minmax_decimator_top DUT (
    .clk        (clk),
    .rst        (rst),
    .sample_in  (sample_in),
    .result_out (result_out),
    .cfg        (cfg)
  );

  // Envelope state as the block should hold it
  logic [SPAN_W-1:0]   span_reg;
  logic [CCOUNT_W-1:0] ccount_reg;
  code_t               peak_max [MAX_CHANNELS];
  code_t               peak_min [MAX_CHANNELS];
  int unsigned         ch_pos;
  int unsigned         bin_idx;
  logic [ACC_W-1:0]    sample_acc;
  logic [ACC_W-1:0]    boundary_acc;
  bit                  run_done;

  bin_result_t pending_bins[$];

  int unsigned mismatches    = 0;
  int unsigned results_seen  = 0;
  int unsigned samples_used  = 0;
  int unsigned items_ignored = 0;
  int unsigned reg_writes    = 0;
  bit          idle_on       = 1'b1;
  bit          long_hold_req = 1'b0;
  bit          offering      = 1'b0;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Channel count as the block uses it
  function automatic int unsigned channels_in_use();
    if (ccount_reg == '0) return 1;
    if (ccount_reg > MAX_CHANNELS) return MAX_CHANNELS;
    return 32'(ccount_reg);
  endfunction

  function automatic logic [ACC_W-1:0] span_step();
    return ACC_W'(span_reg) * ACC_W'(2 * channels_in_use());
  endfunction

  task automatic clear_peaks();
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      peak_max[i] = MAX_EMPTY;
      peak_min[i] = MIN_EMPTY;
    end
  endtask

  task automatic restart_envelope();
    clear_peaks();
    ch_pos       = 0;
    bin_idx      = 0;
    sample_acc   = ACC_W'(BINS);
    boundary_acc = span_step();
    run_done     = 1'b0;
  endtask

  // Queue one result per channel for the current bin
  task automatic close_bin(bit last);
    int unsigned n;
    bin_result_t r;
    n = channels_in_use();
    for (int unsigned ch = 0; ch < n; ch++) begin
      r.bin     = BIN_NUM_W'(bin_idx);
      r.channel = CH_NUM_W'(ch);
      r.max_c   = peak_max[ch];
      r.min_c   = peak_min[ch];
      r.last    = last && (ch + 1 == n);
      pending_bins.push_back(r);
    end
  endtask

  // Advance the envelope by one accepted request
  task automatic track_envelope(logic signed [CODE_W-1:0] hi, logic signed [CODE_W-1:0] lo,
                                logic eod);
    code_t       hi_c;
    code_t       lo_c;
    int unsigned n;
    if (run_done) begin
      items_ignored++;
      return;
    end
    samples_used++;
    n    = channels_in_use();
    hi_c = code_t'(hi) ^ CODE_OFFSET;
    lo_c = code_t'(lo) ^ CODE_OFFSET;
    if (ch_pos >= n) ch_pos = 0;
    // bin crossing is tested on the first channel of a sample
    if (ch_pos == 0) begin
      if (sample_acc > boundary_acc) begin
        if (bin_idx + 1 >= BINS) begin
          close_bin(1'b1);
          run_done = 1'b1;
          return;
        end
        close_bin(1'b0);
        bin_idx++;
        boundary_acc = boundary_acc + span_step();
        clear_peaks();
      end
      sample_acc = sample_acc + ACC_W'(2 * n * BINS);
    end
    if (hi_c > peak_max[ch_pos]) peak_max[ch_pos] = hi_c;
    if (lo_c < peak_min[ch_pos]) peak_min[ch_pos] = lo_c;
    if (eod) begin
      close_bin(1'b1);
      run_done = 1'b1;
      return;
    end
    ch_pos++;
    if (ch_pos >= n) ch_pos = 0;
  endtask

  // Drop valid if the last request was left on the bus
  task automatic release_input();
    if (offering) begin
      sample_in.valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  // Wait until every expected result is out and the pipeline has settled
  task automatic wait_quiet();
    release_input();
    while (pending_bins.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_sample(logic signed [CODE_W-1:0] hi, logic signed [CODE_W-1:0] lo,
                             logic eod);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      sample_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_in.valid       <= 1'b1;
    sample_in.high_value  <= hi;
    sample_in.low_value   <= lo;
    sample_in.end_of_data <= eod;
    offering = 1'b1;
    do @(posedge clk); while (!sample_in.ready);
    track_envelope(hi, lo, eod);
  endtask

  task automatic write_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    wait_quiet();
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx == REG_BIN_SPAN) span_reg = value;
    else ccount_reg = CCOUNT_W'(value);
    restart_envelope();
    reg_writes++;
  endtask

  // Default setup: every sample after the first closes a bin; crossing and
  // end of data on one request give two bins; a finished run ignores requests
  task automatic test_single_channel_bins();
    send_sample(127, -128, 1'b0);
    send_sample(-128, 127, 1'b0);
    send_sample(0, 0, 1'b0);
    send_sample(-1, 1, 1'b1);
    send_sample(5, 5, 1'b0);
    send_sample(0, 0, 1'b1);
  endtask

  // End of data in the middle of a sample; unseen channels keep old or empty values
  task automatic test_partial_sample_end();
    write_register(REG_CHANNEL_COUNT, 3);
    write_register(REG_BIN_SPAN, 32'hFFFF_FFFF);
    send_sample(10, -10, 1'b0);
    send_sample(20, -20, 1'b0);
    send_sample(30, -30, 1'b0);
    send_sample(40, -40, 1'b1);
    write_register(REG_BIN_SPAN, 32'hFFFF_FFFF);
    send_sample(1, -1, 1'b1);
  endtask

  // Channel count zero acts as one, above the maximum acts as the maximum
  task automatic test_channel_clamp();
    write_register(REG_BIN_SPAN, 512);
    write_register(REG_CHANNEL_COUNT, 0);
    send_sample(-77, 66, 1'b0);
    send_sample(33, -44, 1'b1);
    write_register(REG_CHANNEL_COUNT, 15);
    for (int i = 0; i < MAX_CHANNELS; i++) send_sample(8'($urandom), 8'($urandom), 1'b0);
    send_sample(8'($urandom), 8'($urandom), 1'b1);
  endtask

  // Span below the bin count: bins close every sample and may be empty
  task automatic test_zero_span();
    write_register(REG_CHANNEL_COUNT, 2);
    write_register(REG_BIN_SPAN, 0);
    send_sample(100, -100, 1'b0);
    send_sample(-100, 100, 1'b0);
    send_sample(-5, 7, 1'b0);
    send_sample(9, -3, 1'b1);
  endtask

  // Run to the last bin; hold the output off midway, then pause until drained
  task automatic test_full_run();
    write_register(REG_BIN_SPAN, 512);
    write_register(REG_CHANNEL_COUNT, 1);
    for (int i = 0; i <= BINS; i++) begin
      if (i == 100) long_hold_req = 1'b1;
      if (i == 300) wait_quiet();
      send_sample(8'($urandom), 8'($urandom), 1'b0);
    end
    send_sample(8'($urandom), 8'($urandom), 1'b0);
    send_sample(8'($urandom), 8'($urandom), 1'b1);
  endtask

  // Random settings and runs, mostly ended by end of data
  task automatic test_random_runs();
    int unsigned           goal;
    int unsigned           len;
    int unsigned           pick;
    bit                    broken;
    logic                  eod;
    logic [CFG_DATA_W-1:0] span_val;
    logic [CCOUNT_W-1:0]   cc_val;
    goal = samples_used + RANDOM_ITEMS;
    while (samples_used < goal) begin
      if (goal - samples_used < QUIET_ITEMS) idle_on = 1'b0;
      pick = $urandom_range(0, 9);
      if (pick <= 5) span_val = $urandom_range(512, 4096);
      else if (pick == 6) span_val = $urandom_range(0, 511);
      else if (pick == 7) span_val = $urandom;
      else if (pick == 8) span_val = 512;
      else span_val = 32'hFFFF_FFFF;
      if ($urandom_range(0, 9) == 0) cc_val = CCOUNT_W'($urandom_range(0, 15));
      else cc_val = CCOUNT_W'($urandom_range(1, MAX_CHANNELS));
      pick = $urandom_range(0, 2);
      if (pick != 1) write_register(REG_BIN_SPAN, span_val);
      if (pick != 0) write_register(REG_CHANNEL_COUNT, 32'(cc_val));
      len    = $urandom_range(1, 48);
      broken = ($urandom_range(0, 9) == 0);
      for (int i = 1; i <= len; i++) begin
        eod = (i == len && !broken) || ($urandom_range(0, 63) == 0);
        send_sample(8'($urandom), 8'($urandom), eod);
      end
      // keep offering after the run has ended
      if (!broken && $urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) send_sample(8'($urandom), 8'($urandom), 1'($urandom));
      end
    end
  endtask

  // Output side: random stall bursts plus one long hold-off on request
  initial begin : result_receiver
    int unsigned burst;
    result_out.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        result_out.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
        result_out.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 12);
        result_out.ready <= 1'b0;
        repeat (burst) @(posedge clk);
        result_out.ready <= 1'b1;
      end else begin
        result_out.ready <= 1'b1;
      end
    end
  end

  // Compare each accepted result with the oldest expected bin result
  always @(posedge clk) begin : check_results
    bin_result_t got;
    bin_result_t want;
    if (!rst && result_out.valid && result_out.ready) begin
      got = '{result_out.bin_number, result_out.channel_number, result_out.max_code,
              result_out.min_code, result_out.last_of_run};
      results_seen++;
      if (pending_bins.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("ERROR: unexpected result bin %0d ch %0d max %0d min %0d last %0b",
                   got.bin, got.channel, got.max_c, got.min_c, got.last);
      end else begin
        want = pending_bins.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("ERROR: result %0d expected bin %0d ch %0d max %0d min %0d last %0b",
                     results_seen, want.bin, want.channel, want.max_c, want.min_c,
                     want.last);
            $display("       got bin %0d ch %0d max %0d min %0d last %0b",
                     got.bin, got.channel, got.max_c, got.min_c, got.last);
          end
        end
      end
    end
  end

  initial begin : run_limit
    #20_000_000;
    $display("ERROR: timeout with %0d results outstanding", pending_bins.size());
    $display("FAIL");
    $finish;
  end

  initial begin : main_sequence
    int unsigned waited;
    rst                   <= 1'b1;
    sample_in.valid       <= 1'b0;
    sample_in.high_value  <= '0;
    sample_in.low_value   <= '0;
    sample_in.end_of_data <= 1'b0;
    cfg.valid             <= 1'b0;
    cfg.index             <= REG_BIN_SPAN;
    cfg.data              <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    span_reg   = SPAN_RESET;
    ccount_reg = CCOUNT_RESET;
    restart_envelope();

    test_single_channel_bins();
    test_partial_sample_end();
    test_channel_clamp();
    test_zero_span();
    test_full_run();
    test_random_runs();

    // drain what is left, bounded
    idle_on = 1'b0;
    release_input();
    waited = 0;
    while (pending_bins.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (pending_bins.size() != 0) begin
      $display("ERROR: %0d expected results never arrived", pending_bins.size());
      mismatches += pending_bins.size();
    end
    $display("Checked %0d bin results from %0d samples (%0d ignored after run end).",
             results_seen, samples_used, items_ignored);
    $display("Applied %0d register writes; %0d mismatches.", reg_writes, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/wmd_pkg.sv
rtl/wmd_ifs.sv
rtl/wmd_bin_queue.sv
rtl/waveform_minmax_decimator_top.sv
rtl/wmd_checker.sv
test/waveform_minmax_decimator_top_test.sv
